FILE: rtl/magnetometer_heading_top_defines.svh
// Assertion macros for the heading block.
`ifndef MAGNETOMETER_HEADING_TOP_DEFINES_SVH
`define MAGNETOMETER_HEADING_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define MHEAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define MHEAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mhead_pkg.sv
`timescale 1ns / 1ps
package mhead_pkg;

  localparam int AXIS_W    = 16;
  localparam int MAG_W     = 16;
  localparam int UT_W      = 13;
  localparam int HDG_W     = 9;
  localparam int CNT_W     = 6;
  localparam int NUM_CELLS = 44;
  localparam int TAB_W     = 47;
  localparam int PROD_W    = MAG_W + TAB_W;

  // trunc(|raw| * 10 / 109) == (|raw| * UT_MUL) >> UT_SHIFT for |raw| <= 32768
  localparam int UT_MUL_W  = 23;
  localparam int UT_SHIFT  = 26;
  localparam logic [UT_MUL_W-1:0] UT_MUL = 23'd6156780;
  localparam int UT_PROD_W = MAG_W + UT_MUL_W;

  localparam logic [HDG_W-1:0] HDG_MAX = 9'd359;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  // one degree in Q62 radians
  localparam logic [63:0] DEG_STEP_Q62 = PI_Q62 / 64'd180;

  typedef struct packed {
    logic zero;   // x = y = 0
    logic eq;     // folded pair on the 45 degree line
    logic exact;  // angle sits on a multiple of 45 degrees
    logic swap;   // |y| > |x|, octant mirrored
    logic x_neg;
    logic y_neg;
  } flags_t;

  typedef struct packed {
    logic [MAG_W-1:0]      a;
    logic [MAG_W-1:0]      b;
    logic [CNT_W-1:0]      cnt;
    flags_t                flags;
    logic signed [UT_W-1:0] x_ut;
    logic signed [UT_W-1:0] y_ut;
    logic signed [UT_W-1:0] z_ut;
  } cell_data_t;

  typedef struct packed {
    logic signed [UT_W-1:0] z_ut;
    logic signed [UT_W-1:0] y_ut;
    logic signed [UT_W-1:0] x_ut;
    logic [HDG_W-1:0]       hdg;
  } result_t;

  typedef logic [NUM_CELLS:0][TAB_W-1:0] trig_tab_t;

  // (a * b) >> 62 for a, b below 2^63
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // n / d truncated, by shift and subtract
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin or cos of whole degrees from a Q62 series, kept as Q47
  function automatic trig_tab_t build_trig_tab(logic want_sin);
    trig_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] ts;
    logic [63:0] tc;
    tab  = '0;
    for (int k = 0; k <= NUM_CELLS; k++) begin
      x  = DEG_STEP_Q62 * 64'(k);
      x2 = mul_q62(x, x);
      s  = x;
      c  = ONE_Q62;
      ts = x;
      tc = ONE_Q62;
      for (int n = 1; n <= 12; n++) begin
        ts = udiv64(mul_q62(ts, x2), 64'(2 * n) * 64'(2 * n + 1));
        tc = udiv64(mul_q62(tc, x2), 64'(2 * n - 1) * 64'(2 * n));
        if (n[0]) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
      tab[k] = want_sin ? s[61:15] : c[61:15];
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig_tab(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig_tab(1'b1);

endpackage

FILE: rtl/magnetometer_heading_top.sv
// Channel  | Dir | Signals                                   | Content
// s_axis   | in  | s_axis_tvalid, s_axis_tready, s_axis_tdata | raw_x, raw_z, raw_y
// m_axis   | out | m_axis_tvalid, m_axis_tready, m_axis_tdata | heading, x/y/z field in uT
//
// One sample enters per clock while s_axis_tready is high; its result passes through the
// fold register, 44 two-stage cells, the unfold stage and an output queue slot.
// rst_ni clears all valid bits and the output queue; payload is not reset.
// A two-entry output queue keeps the chain moving while m_axis_tready is low;
// the chain stalls as a whole only when both entries are held.
`timescale 1ns / 1ps
`include "magnetometer_heading_top_defines.svh"
module magnetometer_heading_top import mhead_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] raw_x, [31:16] raw_z, [47:32] raw_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [8:0] heading_deg, [21:9] field_x_ut,
                                      // [34:22] field_y_ut, [47:35] field_z_ut
);

  logic                 en;
  cell_data_t           chain_data [NUM_CELLS+1];
  logic [NUM_CELLS:0]   chain_valid;
  logic                 uf_valid;
  result_t              uf_res;
  logic                 push;
  logic                 pop;
  logic [1:0]           q_cnt_q;
  logic [1:0]           q_cnt_d;
  result_t              slot0_q;
  result_t              slot0_d;
  result_t              slot1_q;
  result_t              slot1_d;

  // Advance the whole chain unless the output queue is full and not draining.
  assign en            = (q_cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = en;

  // Fold the sample into the first octant and convert the fields to uT.
  mhead_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .raw_x_i (s_axis_tdata[15:0]),
    .raw_z_i (s_axis_tdata[31:16]),
    .raw_y_i (s_axis_tdata[47:32]),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  // Cell k counts degree k+1 when the folded vector lies at or beyond it,
  // so the count leaving the last cell is the whole-degree floor in the octant.
  genvar gi;
  for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
    mhead_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[gi]),
      .data_i  (chain_data[gi]),
      .cos_i   (COS_TAB[gi+1]),
      .sin_i   (SIN_TAB[gi+1]),
      .valid_o (chain_valid[gi+1]),
      .data_o  (chain_data[gi+1])
    );
  end

  // Unfold the octant count into a 0..359 heading.
  mhead_unfold u_unfold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[NUM_CELLS]),
    .data_i  (chain_data[NUM_CELLS]),
    .valid_o (uf_valid),
    .res_o   (uf_res)
  );

  // Two-entry output queue: slot0 drives the master port.
  assign push = en && uf_valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    q_cnt_d = q_cnt_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push) begin
      if ((q_cnt_q == 2'd0) || ((q_cnt_q == 2'd1) && pop)) begin
        slot0_d = uf_res;
      end else begin
        slot1_d = uf_res;
      end
    end
    q_cnt_d = q_cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= 2'd0;
    end else begin
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign m_axis_tvalid = (q_cnt_q != 2'd0);
  assign m_axis_tdata  = slot0_q;

  // Drop nothing: the chain never delivers into a full, stalled queue.
  `MHEAD_ASSERT_IMP(a_no_overflow, push, (q_cnt_q != 2'd2) || pop, "output queue overflow")
  // Check that the queue fill rises by one on a push without a pop.
  `MHEAD_ASSERT_NXT(a_fill_up, push && !pop, q_cnt_q == $past(q_cnt_q) + 2'd1, "queue fill wrong")
  // Hold the heading in range whenever m_axis_tvalid is high.
  `MHEAD_ASSERT_IMP(a_hdg_range, m_axis_tvalid, m_axis_tdata[8:0] <= HDG_MAX, "heading above 359")

endmodule

FILE: rtl/mhead_prep.sv
`timescale 1ns / 1ps
module mhead_prep import mhead_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [AXIS_W-1:0] raw_x_i,
  input  logic signed [AXIS_W-1:0] raw_z_i,
  input  logic signed [AXIS_W-1:0] raw_y_i,
  output logic                     valid_o,
  output cell_data_t               data_o
);

  logic                   valid_q;
  cell_data_t             data_q;
  cell_data_t             data_d;
  logic [MAG_W-1:0]       ax;
  logic [MAG_W-1:0]       ay;
  logic [MAG_W-1:0]       az;
  logic [UT_PROD_W-1:0]   px;
  logic [UT_PROD_W-1:0]   py;
  logic [UT_PROD_W-1:0]   pz;
  logic [UT_W-1:0]        qx;
  logic [UT_W-1:0]        qy;
  logic [UT_W-1:0]        qz;

  // magnitudes; -32768 maps to 32768 unsigned
  assign ax = raw_x_i[AXIS_W-1] ? (~raw_x_i + 1'b1) : raw_x_i;
  assign ay = raw_y_i[AXIS_W-1] ? (~raw_y_i + 1'b1) : raw_y_i;
  assign az = raw_z_i[AXIS_W-1] ? (~raw_z_i + 1'b1) : raw_z_i;

  assign px = UT_PROD_W'(ax) * UT_PROD_W'(UT_MUL);
  assign py = UT_PROD_W'(ay) * UT_PROD_W'(UT_MUL);
  assign pz = UT_PROD_W'(az) * UT_PROD_W'(UT_MUL);
  assign qx = px[UT_SHIFT +: UT_W];
  assign qy = py[UT_SHIFT +: UT_W];
  assign qz = pz[UT_SHIFT +: UT_W];

  always_comb begin
    data_d             = '0;
    data_d.flags.x_neg = raw_x_i[AXIS_W-1];
    data_d.flags.y_neg = raw_y_i[AXIS_W-1];
    data_d.flags.zero  = (ax == '0) && (ay == '0);
    data_d.x_ut        = raw_x_i[AXIS_W-1] ? -qx : qx;
    data_d.y_ut        = raw_y_i[AXIS_W-1] ? -qy : qy;
    data_d.z_ut        = raw_z_i[AXIS_W-1] ? -qz : qz;
    // fold into 0..45 degrees
    if (ay <= ax) begin
      data_d.a           = ay;
      data_d.b           = ax;
      data_d.flags.swap  = 1'b0;
      data_d.flags.eq    = (ay == ax);
      data_d.flags.exact = (ay == '0) || (ay == ax);
    end else begin
      data_d.a           = ax;
      data_d.b           = ay;
      data_d.flags.swap  = 1'b1;
      data_d.flags.eq    = 1'b0;
      data_d.flags.exact = (ax == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/mhead_cell.sv
`timescale 1ns / 1ps
module mhead_cell import mhead_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  cell_data_t       data_i,
  input  logic [TAB_W-1:0] cos_i,
  input  logic [TAB_W-1:0] sin_i,
  output logic             valid_o,
  output cell_data_t       data_o
);

  logic              valid1_q;
  logic              valid2_q;
  cell_data_t        data1_q;
  cell_data_t        data2_q;
  cell_data_t        data2_d;
  logic [PROD_W-1:0] pc_d;
  logic [PROD_W-1:0] ps_d;
  logic [PROD_W-1:0] pc_q;
  logic [PROD_W-1:0] ps_q;

  // stage one: scale the folded pair by this cell's degree
  assign pc_d = PROD_W'(data_i.a) * PROD_W'(cos_i);
  assign ps_d = PROD_W'(data_i.b) * PROD_W'(sin_i);

  // stage two: count the degree if the vector lies at or above it
  always_comb begin
    data2_d     = data1_q;
    data2_d.cnt = data1_q.cnt + CNT_W'(pc_q >= ps_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data1_q <= data_i;
      pc_q    <= pc_d;
      ps_q    <= ps_d;
      data2_q <= data2_d;
    end
  end

  assign valid_o = valid2_q;
  assign data_o  = data2_q;

endmodule

FILE: rtl/mhead_unfold.sv
`timescale 1ns / 1ps
module mhead_unfold import mhead_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  cell_data_t data_i,
  output logic       valid_o,
  output result_t    res_o
);

  logic             valid_q;
  result_t          res_q;
  result_t          res_d;
  logic [CNT_W-1:0] p;
  logic [6:0]       fa;
  logic [HDG_W-1:0] fa_w;
  logic [HDG_W-1:0] h;

  assign p    = data_i.flags.eq ? 6'd45 : data_i.cnt;
  assign fa   = !data_i.flags.swap ? {1'b0, p} :
                data_i.flags.exact ? (7'd90 - {1'b0, p}) : (7'd89 - {1'b0, p});
  assign fa_w = {2'b00, fa};

  // map the octant angle back to its quadrant
  always_comb begin
    if (!data_i.flags.x_neg && !data_i.flags.y_neg) begin
      h = fa_w;
    end else if (data_i.flags.x_neg && !data_i.flags.y_neg) begin
      h = data_i.flags.exact ? (9'd180 - fa_w) : (9'd179 - fa_w);
    end else if (data_i.flags.x_neg) begin
      h = 9'd180 + fa_w;
    end else begin
      h = data_i.flags.exact ? (9'd360 - fa_w) : (9'd359 - fa_w);
    end
  end

  always_comb begin
    res_d.x_ut = data_i.x_ut;
    res_d.y_ut = data_i.y_ut;
    res_d.z_ut = data_i.z_ut;
    if (data_i.flags.zero) begin
      res_d.hdg = '0;
    end else if (h > HDG_MAX) begin
      res_d.hdg = HDG_MAX;
    end else begin
      res_d.hdg = h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: sim/magnetometer_heading_checker.sv
`timescale 1ns / 1ps
module magnetometer_heading_checker import mhead_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,   // [15:0] raw_x, [31:16] raw_z, [47:32] raw_y
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,   // [8:0] heading, [21:9] x, [34:22] y, [47:35] z in uT
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam real DEG_TO_RAD = 3.14159265358979323846 / 180.0;
  localparam int  MAX_LINES  = 40;

  result_t expected_readings[$];
  int      printed_lines;

  // Heading and field strength of one sample.
  function automatic result_t predict_reading(input logic [47:0] sample);
    logic signed [AXIS_W-1:0] raw_x;
    logic signed [AXIS_W-1:0] raw_z;
    logic signed [AXIS_W-1:0] raw_y;
    int      x;
    int      y;
    int      ax;
    int      ay;
    int      lo;
    int      hi;
    int      cnt;
    int      fold;
    int      hdg;
    bit      exact;
    result_t r;
    raw_x = sample[15:0];
    raw_z = sample[31:16];
    raw_y = sample[47:32];
    x = raw_x;
    y = raw_y;
    r.x_ut = UT_W'(x * 100 / 1090);
    r.y_ut = UT_W'(y * 100 / 1090);
    r.z_ut = UT_W'(int'(raw_z) * 100 / 1090);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax == 0 && ay == 0) begin
      hdg = 0;
    end else begin
      if (ay <= ax) begin
        lo    = ay;
        hi    = ax;
        exact = (ay == 0) || (ay == ax);
      end else begin
        lo    = ax;
        hi    = ay;
        exact = (ax == 0);
      end
      // whole degrees below atan(lo/hi); lattice points never sit on a
      // degree line inside the octant, so real arithmetic decides safely
      cnt = 0;
      if (lo == hi) begin
        cnt = 45;
      end else begin
        for (int k = 1; k < 45; k++) begin
          if (real'(lo) * $cos(k * DEG_TO_RAD) >= real'(hi) * $sin(k * DEG_TO_RAD))
            cnt++;
        end
      end
      if (ay <= ax) fold = cnt;
      else fold = exact ? 90 - cnt : 89 - cnt;
      if (x >= 0 && y >= 0) hdg = fold;
      else if (x < 0 && y >= 0) hdg = exact ? 180 - fold : 179 - fold;
      else if (x < 0) hdg = 180 + fold;
      else hdg = exact ? 360 - fold : 359 - fold;
      if (hdg > int'(HDG_MAX)) hdg = HDG_MAX;
    end
    r.hdg = HDG_W'(hdg);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_cnt_o++;
    if (printed_lines < MAX_LINES) begin
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      printed_lines++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i)
        expected_readings.push_back(predict_reading(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i);
        if (expected_readings.size() == 0) begin
          report_mismatch("result with none pending, heading", int'(got.hdg), -1);
        end else begin
          want = expected_readings.pop_front();
          if (got.hdg !== want.hdg)
            report_mismatch("heading_deg", int'(got.hdg), int'(want.hdg));
          if (got.x_ut !== want.x_ut)
            report_mismatch("field_x_ut", int'(got.x_ut), int'(want.x_ut));
          if (got.y_ut !== want.y_ut)
            report_mismatch("field_y_ut", int'(got.y_ut), int'(want.y_ut));
          if (got.z_ut !== want.z_ut)
            report_mismatch("field_z_ut", int'(got.z_ut), int'(want.z_ut));
        end
      end
      pending_o = expected_readings.size();
    end
  end

endmodule

FILE: sim/magnetometer_heading_top_tb.sv
`timescale 1ns / 1ps
module magnetometer_heading_top_tb;
  import mhead_pkg::*;

  // Random samples per idle phase; three phases follow the directed samples.
  localparam int RANDOM_PER_PHASE = 250;
  // Start the long receiver hold-off well inside the last (no idle) phase.
  localparam int HOLD_AT          = 600;
  // Long enough for the pipe and its two-entry output queue to fill.
  localparam int HOLD_CYCLES      = 300;
  // Once nothing is pending, watch on for stray results.
  localparam int DRAIN_CYCLES     = 120;
  localparam int CYCLE_LIMIT      = 200000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // [15:0] raw_x, [31:16] raw_z, [47:32] raw_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [8:0] heading_deg, [21:9] field_x_ut,
                                     // [34:22] field_y_ut, [47:35] field_z_ut

  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  logic   rx_hold     = 1'b0;
  int     accepted_cnt;
  int     fail_cnt;
  int     pending_cnt;
  longint cycle_cnt;

  always #5 clk_i = ~clk_i;

  magnetometer_heading_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Watch both channels, predict each sample and compare the results.
  magnetometer_heading_checker u_heading_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  // Receiver: stall at the phase's idle rate; drop ready entirely during a hold-off.
  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long hold-off, counted here: the sender keeps offering, so the pipe fills
  // up and has to lower s_axis_tready.
  initial begin
    wait (accepted_cnt >= HOLD_AT);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one sample and hold it until the transaction completes. Valid stays
  // high between back-to-back samples; it only drops during sender idle cycles.
  task automatic send_sample(input int x, input int z, input int y);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {16'(y), 16'(z), 16'(x)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accepted_cnt++;
  endtask

  // Mix full-range words (every bit toggles), tiny vectors around the origin,
  // and points on the axes and diagonals where the angle is a multiple of 45.
  task automatic send_random_batch(input int count);
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] v;
    for (int i = 0; i < count; i++) begin
      v = 16'($urandom);
      case ($urandom_range(3))
        0, 1: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        2: begin
          x = 16'(int'($urandom_range(16)) - 8);
          y = 16'(int'($urandom_range(16)) - 8);
        end
        default: begin
          case ($urandom_range(3))
            0: begin x = v;     y = v;     end
            1: begin x = v;     y = -v;    end
            2: begin x = '0;    y = v;     end
            default: begin x = v; y = '0; end
          endcase
        end
      endcase
      send_sample(int'(x), int'($urandom_range(16'hFFFF)), int'(y));
    end
  endtask

  initial begin
    // Phase one idling: sender idles often, receiver stalls most cycles.
    tx_idle_pct = 21;
    rx_idle_pct = 70;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples, arguments in register order x, z, y.
    send_sample(0, 0, 0);                     // zero vector
    send_sample(-5, 0, 0);                    // negative X axis
    send_sample(-32768, -32768, 0);           // most negative raw, 180 degrees
    send_sample(32767, 32767, 0);             // positive X axis, full scale
    send_sample(0, 0, 32767);                 // 90
    send_sample(0, 0, -32768);                // 270
    send_sample(32767, -32768, 32767);        // 45
    send_sample(-32767, 0, 32767);            // 135
    send_sample(-32768, 0, -32768);           // 225
    send_sample(32767, 0, -32767);            // 315
    send_sample(1, 0, -1);
    send_sample(-1, 0, -1);
    send_sample(1, 0, -32768);                // just past 270
    send_sample(-1, 0, -32768);               // just short of 270
    send_sample(32767, 0, -1);                // just short of a full turn
    send_sample(1, 0, 32767);                 // just short of 90
    send_sample(-32768, 0, 1);                // just short of 180
    send_sample(-32768, 0, -1);               // just past 180
    send_sample(1090, 10900, -1090);          // exact uT conversions
    send_sample(1089, -1089, 1);
    send_sample(32767, 0, 572);               // near the 1 degree line
    send_sample(32767, 0, 571);
    send_sample(-1, 1, 1);

    send_random_batch(RANDOM_PER_PHASE);

    // Phase two: the other way round.
    tx_idle_pct = 70;
    rx_idle_pct = 21;
    send_random_batch(RANDOM_PER_PHASE);

    // Phase three: no idling; the hold-off lands in here.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_batch(RANDOM_PER_PHASE);
    s_axis_tvalid <= 1'b0;

    // Let the checker see the last transaction, then wait for the pipe to drain.
    @(posedge clk_i);
    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mhead_pkg.sv
rtl/mhead_prep.sv
rtl/mhead_cell.sv
rtl/mhead_unfold.sv
rtl/magnetometer_heading_top.sv
sim/magnetometer_heading_checker.sv
sim/magnetometer_heading_top_tb.sv
